### rtl/swtb_pkg.sv
package swtb_pkg;

  // bank size and derived widths
  localparam int NUM_TIMERS = 16;
  localparam int TIMER_ID_W = 4;
  localparam int KIND_W     = 4;
  localparam int VALUE_W    = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int CMP_W      = (CNT_W > TIMER_ID_W) ? CNT_W : TIMER_ID_W;

  // command codes
  localparam logic [KIND_W-1:0] K_TICK     = 4'd0;
  localparam logic [KIND_W-1:0] K_CREATE   = 4'd1;
  localparam logic [KIND_W-1:0] K_DELETE   = 4'd2;
  localparam logic [KIND_W-1:0] K_START    = 4'd3;
  localparam logic [KIND_W-1:0] K_RESTART  = 4'd4;
  localparam logic [KIND_W-1:0] K_STOP     = 4'd5;
  localparam logic [KIND_W-1:0] K_CLRCOUNT = 4'd6;
  localparam logic [KIND_W-1:0] K_SETLIMIT = 4'd7;
  localparam logic [KIND_W-1:0] K_CLRTMO   = 4'd8;
  localparam logic [KIND_W-1:0] K_QUERY    = 4'd9;

  // stored state of one timer
  typedef struct packed {
    logic [VALUE_W-1:0] limit;
    logic [VALUE_W-1:0] count;
    logic               timed_out;
    logic               running;
    logic               in_use;
    logic               reload_mode;
  } timer_state_t;

  // command broadcast to every timer
  typedef struct packed {
    logic               tick;
    logic               hit;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               mode;
  } timer_cmd_t;

endpackage

### rtl/swtb_timer.sv
module swtb_timer (
  input  logic                    clk,
  input  logic                    rst,
  input  swtb_pkg::timer_cmd_t    cmd,
  output swtb_pkg::timer_state_t  state,
  output swtb_pkg::timer_state_t  state_next
);

  logic [swtb_pkg::VALUE_W-1:0] count_inc;

  assign count_inc = state.count + swtb_pkg::VALUE_W'(1);

  // tick advance or addressed command
  always_comb begin
    state_next = state;
    if (cmd.tick) begin
      if (state.in_use && state.running) begin
        if (count_inc == state.limit) begin
          state_next.count     = '0;
          state_next.timed_out = 1'b1;
          state_next.running   = 1'b0;
        end else begin
          state_next.count = count_inc;
        end
      end
    end else if (cmd.hit) begin
      case (cmd.kind)
        swtb_pkg::K_CREATE: begin
          if (!state.in_use) begin
            state_next.limit       = cmd.value;
            state_next.count       = '0;
            state_next.timed_out   = 1'b0;
            state_next.running     = 1'b0;
            state_next.in_use      = 1'b1;
            state_next.reload_mode = cmd.mode;
          end
        end
        swtb_pkg::K_DELETE: begin
          if (state.in_use) begin
            state_next.timed_out   = 1'b0;
            state_next.running     = 1'b0;
            state_next.in_use      = 1'b0;
            state_next.reload_mode = 1'b0;
          end
        end
        swtb_pkg::K_START: begin
          state_next.running = 1'b1;
        end
        swtb_pkg::K_RESTART: begin
          state_next.running   = 1'b1;
          state_next.timed_out = 1'b0;
        end
        swtb_pkg::K_STOP: begin
          state_next.running = 1'b0;
        end
        swtb_pkg::K_CLRCOUNT: begin
          state_next.count = '0;
        end
        swtb_pkg::K_SETLIMIT: begin
          state_next.limit = cmd.value;
        end
        swtb_pkg::K_CLRTMO: begin
          state_next.timed_out = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // timer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/software_timer_bank.sv
// a result strobes on done once the item has passed the input register and the result register
// throughput: one item per cycle, busy is never raised
// a tick advances every used, running timer of the bank in that same cycle
// the receiver cannot stall, each result shows for one cycle only
// synchronous reset clears every timer (unused, stopped, zero)
module software_timer_bank (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [swtb_pkg::KIND_W-1:0]       kind,
  input  logic [swtb_pkg::TIMER_ID_W-1:0]   timer_id,
  input  logic [swtb_pkg::VALUE_W-1:0]      value,
  input  logic                              mode,
  output logic                              done,
  output logic                              status,
  output logic                              timed_out,
  output logic                              running,
  output logic                              in_use,
  output logic                              reload_mode,
  output logic [swtb_pkg::VALUE_W-1:0]      count_value,
  output logic [swtb_pkg::VALUE_W-1:0]      limit_value
);

  logic                            in_valid;
  logic [swtb_pkg::KIND_W-1:0]     in_kind;
  logic [swtb_pkg::TIMER_ID_W-1:0] in_id;
  logic [swtb_pkg::VALUE_W-1:0]    in_value;
  logic                            in_mode;

  logic [swtb_pkg::CMP_W-1:0]      id_ext;
  logic                            id_present;
  logic [swtb_pkg::IDX_W-1:0]      idx;
  logic                            is_tick;

  swtb_pkg::timer_cmd_t            cell_cmd   [swtb_pkg::NUM_TIMERS];
  swtb_pkg::timer_state_t          cell_state [swtb_pkg::NUM_TIMERS];
  swtb_pkg::timer_state_t          cell_next  [swtb_pkg::NUM_TIMERS];

  swtb_pkg::timer_state_t          sel_state;
  swtb_pkg::timer_state_t          sel_next;
  logic                            status_next;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_kind  <= kind;
      in_id    <= timer_id;
      in_value <= value;
      in_mode  <= mode;
    end
  end

  // address decode
  assign id_ext     = swtb_pkg::CMP_W'(in_id);
  assign id_present = id_ext < swtb_pkg::CMP_W'(swtb_pkg::NUM_TIMERS);
  assign idx        = id_ext[swtb_pkg::IDX_W-1:0];
  assign is_tick    = in_valid && (in_kind == swtb_pkg::K_TICK);

  // timer cells
  for (genvar i = 0; i < swtb_pkg::NUM_TIMERS; i++) begin : g_timer
    assign cell_cmd[i].tick  = is_tick;
    assign cell_cmd[i].hit   = in_valid && (id_ext == swtb_pkg::CMP_W'(i));
    assign cell_cmd[i].kind  = in_kind;
    assign cell_cmd[i].value = in_value;
    assign cell_cmd[i].mode  = in_mode;

    swtb_timer u_timer (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd[i]),
      .state      (cell_state[i]),
      .state_next (cell_next[i])
    );
  end

  // addressed timer and status
  always_comb begin
    sel_state   = '0;
    sel_next    = '0;
    status_next = 1'b0;
    if (id_present) begin
      sel_state = cell_state[idx];
      sel_next  = cell_next[idx];
      if (in_kind == swtb_pkg::K_CREATE) begin
        status_next = sel_state.in_use;
      end else if (in_kind == swtb_pkg::K_DELETE) begin
        status_next = !sel_state.in_use;
      end
    end else begin
      status_next = (in_kind == swtb_pkg::K_CREATE) || (in_kind == swtb_pkg::K_DELETE);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      status      <= status_next;
      timed_out   <= sel_next.timed_out;
      running     <= sel_next.running;
      in_use      <= sel_next.in_use;
      reload_mode <= sel_next.reload_mode;
      count_value <= sel_next.count;
      limit_value <= sel_next.limit;
    end
  end

endmodule

### rtl/swtb_checker.sv
module swtb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic in_use,
  input logic reload_mode
);

  // every item taken gives a result on done
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("item taken without a result");

  // no result without an item taken before it
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an item");

  // mode bit is only stored on a created timer
  a_mode_used: assert property (@(posedge clk) disable iff (rst)
    (done && reload_mode) |-> in_use)
    else $error("reload mode on an unused timer");

  // bank takes an item every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind software_timer_bank swtb_checker u_swtb_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .in_use      (in_use),
  .reload_mode (reload_mode)
);

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  // kinds above query are undefined and must answer like a query
  localparam logic [swtb_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = swtb_pkg::K_QUERY + 1'b1;
  localparam logic [swtb_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = '1;
  localparam int RANDOM_ITEMS     = 1650;
  localparam int NO_IDLE_TAIL     = 250;
  localparam int STALL_LIMIT      = 500;
  localparam int DRAIN_CYCLES     = 8;
  localparam int ZERO_LIMIT_TICKS = 40;

  // one result item as seen on the ports
  typedef struct packed {
    logic                         status;
    logic                         timed_out;
    logic                         running;
    logic                         in_use;
    logic                         reload_mode;
    logic [swtb_pkg::VALUE_W-1:0] count_value;
    logic [swtb_pkg::VALUE_W-1:0] limit_value;
  } timer_result_t;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic [swtb_pkg::KIND_W-1:0]     kind;
  logic [swtb_pkg::TIMER_ID_W-1:0] timer_id;
  logic [swtb_pkg::VALUE_W-1:0]    value;
  logic                            mode;
  logic                            done;
  logic                            status;
  logic                            timed_out;
  logic                            running;
  logic                            in_use;
  logic                            reload_mode;
  logic [swtb_pkg::VALUE_W-1:0]    count_value;
  logic [swtb_pkg::VALUE_W-1:0]    limit_value;

  // shadow copy of the timer bank
  logic [swtb_pkg::VALUE_W-1:0] bank_limit [swtb_pkg::NUM_TIMERS];
  logic [swtb_pkg::VALUE_W-1:0] bank_count [swtb_pkg::NUM_TIMERS];
  logic                         bank_used  [swtb_pkg::NUM_TIMERS];
  logic                         bank_run   [swtb_pkg::NUM_TIMERS];
  logic                         bank_tmo   [swtb_pkg::NUM_TIMERS];
  logic                         bank_mode  [swtb_pkg::NUM_TIMERS];

  timer_result_t pending_results[$];
  timer_result_t oldest_result;
  int            error_count;
  int            items_sent;
  int            stall_cycles;
  bit            idle_on;

  software_timer_bank dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .timer_id    (timer_id),
    .value       (value),
    .mode        (mode),
    .done        (done),
    .status      (status),
    .timed_out   (timed_out),
    .running     (running),
    .in_use      (in_use),
    .reload_mode (reload_mode),
    .count_value (count_value),
    .limit_value (limit_value)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // apply one item to the shadow bank and return the answer it should give
  function automatic timer_result_t step_bank(input logic [swtb_pkg::KIND_W-1:0] k,
                                              input logic [swtb_pkg::TIMER_ID_W-1:0] id,
                                              input logic [swtb_pkg::VALUE_W-1:0] v,
                                              input logic m);
    timer_result_t                r;
    logic [swtb_pkg::VALUE_W-1:0] c;
    int                           i;
    r = '0;
    i = int'(id);
    // a tick advances every used, running timer
    if (k == swtb_pkg::K_TICK) begin
      for (int t = 0; t < swtb_pkg::NUM_TIMERS; t++) begin
        if (bank_used[t] && bank_run[t]) begin
          c = bank_count[t] + swtb_pkg::VALUE_W'(1);
          if (c == bank_limit[t]) begin
            bank_tmo[t] = 1'b1;
            bank_run[t] = 1'b0;
            c = '0;
          end
          bank_count[t] = c;
        end
      end
    end
    // absent timer: command ignored, only create and delete report failure
    if (i >= swtb_pkg::NUM_TIMERS) begin
      r.status = (k == swtb_pkg::K_CREATE) || (k == swtb_pkg::K_DELETE);
      return r;
    end
    case (k)
      swtb_pkg::K_CREATE: begin
        if (bank_used[i]) begin
          r.status = 1'b1;
        end else begin
          bank_limit[i] = v;
          bank_count[i] = '0;
          bank_used[i]  = 1'b1;
          bank_mode[i]  = m;
          bank_run[i]   = 1'b0;
          bank_tmo[i]   = 1'b0;
        end
      end
      swtb_pkg::K_DELETE: begin
        if (bank_used[i]) begin
          bank_used[i] = 1'b0;
          bank_mode[i] = 1'b0;
          bank_run[i]  = 1'b0;
          bank_tmo[i]  = 1'b0;
        end else begin
          r.status = 1'b1;
        end
      end
      swtb_pkg::K_START:    bank_run[i] = 1'b1;
      swtb_pkg::K_RESTART: begin
        bank_run[i] = 1'b1;
        bank_tmo[i] = 1'b0;
      end
      swtb_pkg::K_STOP:     bank_run[i] = 1'b0;
      swtb_pkg::K_CLRCOUNT: bank_count[i] = '0;
      swtb_pkg::K_SETLIMIT: bank_limit[i] = v;
      swtb_pkg::K_CLRTMO:   bank_tmo[i] = 1'b0;
      default: ;
    endcase
    r.timed_out   = bank_tmo[i];
    r.running     = bank_run[i];
    r.in_use      = bank_used[i];
    r.reload_mode = bank_mode[i];
    r.count_value = bank_count[i];
    r.limit_value = bank_limit[i];
    return r;
  endfunction

  // send one item, with an optional idle burst ahead of it
  task automatic send_cmd(input logic [swtb_pkg::KIND_W-1:0] k,
                          input logic [swtb_pkg::TIMER_ID_W-1:0] id,
                          input logic [swtb_pkg::VALUE_W-1:0] v, input logic m);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk);
      start    <= 1'b0;
      kind     <= swtb_pkg::KIND_W'($urandom);
      timer_id <= swtb_pkg::TIMER_ID_W'($urandom);
      value    <= swtb_pkg::VALUE_W'($urandom);
      mode     <= 1'($urandom);
    end
    @(negedge clk);
    start    <= 1'b1;
    kind     <= k;
    timer_id <= id;
    value    <= v;
    mode     <= m;
    do @(posedge clk); while (busy);
    pending_results.push_back(step_bank(k, id, v, m));
    items_sent++;
  endtask

  // get a freshly created timer at id
  task automatic fresh_timer(input logic [swtb_pkg::TIMER_ID_W-1:0] id,
                             input logic [swtb_pkg::VALUE_W-1:0] lim, input logic m);
    if (bank_used[int'(id)]) send_cmd(swtb_pkg::K_DELETE, id, '0, 1'b0);
    send_cmd(swtb_pkg::K_CREATE, id, lim, m);
  endtask

  // one random command, mostly on a few timers with short limits
  task automatic send_noise();
    logic [swtb_pkg::KIND_W-1:0]     k;
    logic [swtb_pkg::TIMER_ID_W-1:0] id;
    logic [swtb_pkg::VALUE_W-1:0]    v;
    if ($urandom_range(0, 7) == 0) k = swtb_pkg::KIND_W'($urandom_range(KIND_UNUSED_FIRST,
                                                                        KIND_UNUSED_LAST));
    else k = swtb_pkg::KIND_W'($urandom_range(swtb_pkg::K_TICK, swtb_pkg::K_QUERY));
    if ($urandom_range(0, 3) == 0) id = swtb_pkg::TIMER_ID_W'($urandom);
    else id = swtb_pkg::TIMER_ID_W'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) v = swtb_pkg::VALUE_W'($urandom_range(1, 20));
    else v = swtb_pkg::VALUE_W'($urandom);
    send_cmd(k, id, v, 1'($urandom));
  endtask

  // create, start and tick a timer past its limit, with noise mixed in
  task automatic run_episode();
    logic [swtb_pkg::TIMER_ID_W-1:0] id;
    int                              lim;
    id  = swtb_pkg::TIMER_ID_W'($urandom);
    lim = $urandom_range(1, 10);
    fresh_timer(id, swtb_pkg::VALUE_W'(lim), 1'($urandom));
    send_cmd(swtb_pkg::K_START, id, swtb_pkg::VALUE_W'($urandom), 1'($urandom));
    repeat (lim + $urandom_range(0, 3)) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      send_cmd(swtb_pkg::K_TICK, swtb_pkg::TIMER_ID_W'($urandom),
               swtb_pkg::VALUE_W'($urandom), 1'($urandom));
    end
    case ($urandom_range(0, 3))
      0: send_cmd(swtb_pkg::K_RESTART, id, '0, 1'b0);
      1: send_cmd(swtb_pkg::K_CLRTMO, id, '0, 1'b0);
      2: send_cmd(swtb_pkg::K_STOP, id, '0, 1'b0);
      default: send_cmd(swtb_pkg::K_QUERY, id, '0, 1'b0);
    endcase
  endtask

  // create and delete rules, including the failing cases
  task automatic test_create_delete();
    send_cmd(swtb_pkg::K_QUERY, 4'd5, '0, 1'b0);
    send_cmd(swtb_pkg::K_CREATE, 4'd0, '1, 1'b1);
    send_cmd(swtb_pkg::K_CREATE, 4'd0, '0, 1'b0);
    send_cmd(swtb_pkg::K_DELETE, 4'd9, '0, 1'b0);
    send_cmd(swtb_pkg::K_CREATE, 4'd15, '0, 1'b0);
    send_cmd(swtb_pkg::K_DELETE, 4'd15, '1, 1'b1);
    send_cmd(swtb_pkg::K_DELETE, 4'd15, '0, 1'b0);
  endtask

  // flag commands on an unused timer, and undefined kinds
  task automatic test_flag_commands();
    send_cmd(swtb_pkg::K_START, 4'd7, '0, 1'b0);
    send_cmd(swtb_pkg::K_TICK, 4'd7, '0, 1'b0);
    send_cmd(swtb_pkg::K_SETLIMIT, 4'd7, 16'h1234, 1'b1);
    send_cmd(swtb_pkg::K_CLRCOUNT, 4'd7, '0, 1'b0);
    send_cmd(swtb_pkg::K_CLRTMO, 4'd7, '0, 1'b0);
    send_cmd(swtb_pkg::K_RESTART, 4'd7, '0, 1'b0);
    send_cmd(swtb_pkg::K_STOP, 4'd7, '0, 1'b0);
    send_cmd(KIND_UNUSED_FIRST, 4'd0, '1, 1'b1);
    send_cmd(KIND_UNUSED_LAST, 4'd0, '1, 1'b0);
  endtask

  // a short limit reached, then restart, clear and stop
  task automatic test_timeout_path();
    send_cmd(swtb_pkg::K_CREATE, 4'd1, 16'd3, 1'b0);
    send_cmd(swtb_pkg::K_START, 4'd1, '0, 1'b0);
    repeat (4) send_cmd(swtb_pkg::K_TICK, 4'd1, '0, 1'b0);
    send_cmd(swtb_pkg::K_RESTART, 4'd1, '0, 1'b0);
    send_cmd(swtb_pkg::K_TICK, 4'd1, '0, 1'b0);
    send_cmd(swtb_pkg::K_CLRCOUNT, 4'd1, '0, 1'b0);
    send_cmd(swtb_pkg::K_CLRTMO, 4'd1, '0, 1'b0);
    send_cmd(swtb_pkg::K_STOP, 4'd1, '0, 1'b0);
  endtask

  // zero and full limits keep counting without an early match
  task automatic test_zero_limit_wrap();
    fresh_timer(4'd2, '0, 1'b0);
    fresh_timer(4'd3, '1, 1'b1);
    send_cmd(swtb_pkg::K_START, 4'd2, '0, 1'b0);
    send_cmd(swtb_pkg::K_START, 4'd3, '0, 1'b0);
    for (int n = 0; n < ZERO_LIMIT_TICKS; n++)
      send_cmd(swtb_pkg::K_TICK, swtb_pkg::TIMER_ID_W'(2 + (n & 1)), '0, 1'b0);
    send_cmd(swtb_pkg::K_QUERY, 4'd2, '0, 1'b0);
    send_cmd(swtb_pkg::K_QUERY, 4'd3, '0, 1'b0);
  endtask

  // random episodes and noise, no idling toward the end
  task automatic test_random_traffic();
    int last_item;
    last_item = items_sent + RANDOM_ITEMS;
    while (items_sent < last_item) begin
      if (items_sent > last_item - NO_IDLE_TAIL) idle_on = 1'b0;
      else if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 2) == 0) send_noise();
      else run_episode();
    end
  endtask

  // compare one field of a result
  task automatic check_field(input string name, input logic [swtb_pkg::VALUE_W-1:0] exp_v,
                             input logic [swtb_pkg::VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", swtb_pkg::VALUE_W'(oldest_result.status),
                    swtb_pkg::VALUE_W'(status));
        check_field("timed_out", swtb_pkg::VALUE_W'(oldest_result.timed_out),
                    swtb_pkg::VALUE_W'(timed_out));
        check_field("running", swtb_pkg::VALUE_W'(oldest_result.running),
                    swtb_pkg::VALUE_W'(running));
        check_field("in_use", swtb_pkg::VALUE_W'(oldest_result.in_use),
                    swtb_pkg::VALUE_W'(in_use));
        check_field("reload_mode", swtb_pkg::VALUE_W'(oldest_result.reload_mode),
                    swtb_pkg::VALUE_W'(reload_mode));
        check_field("count_value", oldest_result.count_value, count_value);
        check_field("limit_value", oldest_result.limit_value, limit_value);
      end
    end
  end

  // watchdog on cycles with no accepted item and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("software_timer_bank verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    kind         = '0;
    timer_id     = '0;
    value        = '0;
    mode         = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    for (int t = 0; t < swtb_pkg::NUM_TIMERS; t++) begin
      bank_limit[t] = '0;
      bank_count[t] = '0;
      bank_used[t]  = 1'b0;
      bank_run[t]   = 1'b0;
      bank_tmo[t]   = 1'b0;
      bank_mode[t]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_create_delete();
    test_flag_commands();
    test_timeout_path();
    idle_on = 1'b0;
    test_zero_limit_wrap();
    idle_on = 1'b1;
    test_random_traffic();

    // drain outstanding results
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("software_timer_bank verification clean");
    end else begin
      $display("software_timer_bank verification failed");
    end
    $finish;
  end

endmodule
